>>> hw/rtl/tpmtis_pkg.sv
// ----------------------------------------------------------------------------
// TPM TIS package
// Shared types, codes and constants of the TIS register front end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpmtis_pkg;

  localparam int BUFFER_BYTES_DEF   = 4096;
  localparam int LOCALITY_COUNT_DEF = 5;
  localparam int CFG_IDX_W          = 2;

  typedef enum logic [2:0] {
    MODE_HOST_READ    = 3'd0,
    MODE_HOST_WRITE   = 3'd1,
    MODE_RESP_BYTE    = 3'd2,
    MODE_CMD_FETCH    = 3'd3,
    MODE_BACKEND_GONE = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CST_IDLE       = 3'd0,
    CST_READY      = 3'd1,
    CST_COMPLETION = 3'd2,
    CST_EXECUTION  = 3'd3,
    CST_RECEPTION  = 3'd4
  } cmd_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IRQ_VECTOR      = 2'd0,
    CFG_BACKEND_PRESENT = 2'd1,
    CFG_DEV_VENDOR_ID   = 2'd2,
    CFG_REVISION_ID     = 2'd3
  } cfg_idx_e;

  localparam logic [11:0] REG_ACCESS     = 12'h000;
  localparam logic [11:0] REG_INT_ENABLE = 12'h008;
  localparam logic [11:0] REG_INT_VECTOR = 12'h00c;
  localparam logic [11:0] REG_INT_STATUS = 12'h010;
  localparam logic [11:0] REG_INTF_CAP   = 12'h014;
  localparam logic [11:0] REG_STS        = 12'h018;
  localparam logic [11:0] REG_DATA_FIFO  = 12'h024;
  localparam logic [11:0] REG_DID_VID    = 12'hf00;
  localparam logic [11:0] REG_RID        = 12'hf04;

  localparam logic [2:0]  NO_LOC        = 3'd7;
  localparam logic [7:0]  IRQ_DATA      = 8'h01;
  localparam logic [7:0]  IRQ_LOCCHG    = 8'h04;
  localparam logic [7:0]  IRQ_READY     = 8'h80;
  localparam logic [7:0]  IRQ_SUPPORTED = 8'h85;
  localparam logic [31:0] INT_EN_MASK   = 32'h8000_009d;
  localparam logic [3:0]  FAIL_LEN      = 4'd10;

  typedef struct packed {
    logic [2:0]  mode;
    logic [14:0] addr;
    logic [31:0] wdata;
    logic [7:0]  resp_byte;
    logic        resp_last;
    logic [11:0] fetch_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq_line;
    logic        send_request;
    logic [2:0]  send_locality;
    logic [12:0] send_length;
  } out_word_t;

  function automatic logic [7:0] fail_byte(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd5:    b = 8'h0a;
      4'd9:    b = 8'h09;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/tpmtis_ram.sv
// ----------------------------------------------------------------------------
// TPM TIS RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpmtis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/tpm_tis_register_interface.sv
// ----------------------------------------------------------------------------
// TPM TIS register interface
// TIS 1.2 front end: locality arbitration, command state, interrupts and a
// shared command/response byte buffer held in one RAM.
// ----------------------------------------------------------------------------
//  channel  signals                              direction
//  in       in_valid_i in_stall_o in_word_i      host/backend words in
//  out      out_valid_o out_stall_i out_word_o   one result word per input
//  cfg      cfg_we_i cfg_idx_i cfg_wdata_i       register writes
//
// Each word goes through accept, buffer RAM read, then update and result; no
// new word is taken until it is through. A failure response writes 10 bytes
// into the buffer before the next word. After reset the buffer is cleared while in_stall_o is high.
// A stalled result holds the update until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpm_tis_register_interface
  import tpmtis_pkg::*;
#(
  parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
  parameter int LOCALITY_COUNT = LOCALITY_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int LC = LOCALITY_COUNT;

  typedef struct packed {
    logic [PW-1:0]        fp;
    logic [PW-1:0]        rp;
    logic [2:0]           act;
    logic [2:0]           abt;
    logic [2:0]           nxt;
    logic                 pend;
    logic [LC-1:0][2:0]   cst;
    logic [LC-1:0][7:0]   acc;
    logic [LC-1:0][7:0]   sts;
    logic [LC-1:0][31:0]  ien;
    logic [LC-1:0][7:0]   ist;
  } ctl_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_READ, S_APPLY, S_FAIL
  } st_e;

  function automatic ctl_t ctl_reset();
    ctl_t r;
    r.fp   = '0;
    r.rp   = '0;
    r.act  = NO_LOC;
    r.abt  = NO_LOC;
    r.nxt  = NO_LOC;
    r.pend = 1'b0;
    for (int c = 0; c < LC; c++) begin
      r.cst[c] = CST_IDLE;
      r.acc[c] = 8'h80;
      r.sts[c] = 8'h00;
      r.ien[c] = 32'h0000_0008;
      r.ist[c] = 8'h00;
    end
    return r;
  endfunction

  function automatic ctl_t raise_f(ctl_t s, logic [2:0] l, logic [7:0] m);
    ctl_t r;
    r = s;
    if (l < LC) begin
      if (!r.pend && r.ien[l][31] && |(r.ien[l][7:0] & m) && !(|(r.ist[l] & m))) begin
        r.pend   = 1'b1;
        r.ist[l] = r.ist[l] | m;
      end
    end
    return r;
  endfunction

  function automatic ctl_t finish_f(ctl_t s);
    ctl_t r;
    logic [2:0] ab;
    logic [2:0] nx;
    r  = s;
    ab = s.abt;
    nx = s.nxt;
    r.fp  = '0;
    r.act = nx;
    if (ab < LC && ab == nx) begin
      r.cst[ab] = CST_READY;
      r.sts[ab] = 8'h40;
      r = raise_f(r, ab, IRQ_READY);
    end
    if (ab != nx && nx < LC) begin
      if (ab < LC) r.acc[ab] = r.acc[ab] & ~8'h20;
      r.acc[nx] = r.acc[nx] | 8'h20;
      r = raise_f(r, nx, IRQ_LOCCHG);
    end
    r.abt = NO_LOC;
    return r;
  endfunction

  function automatic ctl_t start_f(ctl_t s, logic [2:0] l, logic [2:0] nl, logic bp);
    ctl_t r;
    r     = s;
    r.abt = l;
    r.nxt = nl;
    if (!(l < LC && r.cst[l] == CST_EXECUTION && bp)) r = finish_f(r);
    return r;
  endfunction

  function automatic ctl_t complete_f(ctl_t s);
    ctl_t r;
    r = s;
    if (s.act < LC) begin
      r.sts[s.act] = 8'h90;
      r.cst[s.act] = CST_COMPLETION;
      r = raise_f(r, s.act, IRQ_DATA);
    end
    return r;
  endfunction

  function automatic logic [31:0] hlen_f(logic [7:0] b4, logic [7:0] b5);
    logic [31:0] n;
    n = {16'h0000, b4, b5};
    return (n > BUFFER_BYTES) ? 32'(BUFFER_BYTES) : n;
  endfunction

  st_e         st_q, st_d;
  ctl_t        ctl_q, ctl_d;
  in_word_t    item_q;
  out_word_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  h1_q, h1_d, h4_q, h4_d, h5_q, h5_d;
  logic [7:0]  tag_q, tag_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [7:0]  irq_vector_q;
  logic        backend_present_q;
  logic [31:0] dev_vendor_id_q;
  logic [7:0]  revision_id_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          ap_we;
  logic [AW-1:0] ap_waddr;
  logic [7:0]    ap_wdata;
  logic          ap_fail;
  logic          go;
  logic [31:0]   fi32;
  logic          in_acc;

  assign in_stall_o  = (st_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign go          = !(out_valid_q && out_stall_i);
  assign fi32        = 32'(item_q.fetch_index);
  assign ram_raddr   = (item_q.mode == MODE_CMD_FETCH) ? fi32[AW-1:0] : ctl_q.fp[AW-1:0];

  tpmtis_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // update of control state, buffer write and result word for one word
  always_comb begin
    ctl_t        n;
    logic [2:0]  l;
    logic [11:0] off;
    logic [31:0] v;
    logic [31:0] val;
    logic [2:0]  nl;
    logic        found;
    logic [7:0]  b;
    n        = ctl_q;
    h1_d     = h1_q;
    h4_d     = h4_q;
    h5_d     = h5_q;
    tag_d    = tag_q;
    ap_we    = 1'b0;
    ap_waddr = '0;
    ap_wdata = '0;
    ap_fail  = 1'b0;
    out_d    = '0;
    v        = '0;
    nl       = NO_LOC;
    found    = 1'b0;
    b        = item_q.resp_byte;
    l        = item_q.addr[14:12];
    val      = item_q.wdata;
    off      = item_q.addr[11:0];
    case (item_q.mode)
      MODE_HOST_READ: begin
        if (l < LC) begin
          case ({off[11:2], 2'b00})
            REG_ACCESS: begin
              if (n.act == l) n.acc[l] = n.acc[l] | 8'h20;
              else            n.acc[l] = n.acc[l] & ~8'h20;
              v = 32'(n.acc[l]);
            end
            REG_INT_ENABLE: v = n.ien[l];
            REG_INT_VECTOR: v = 32'(irq_vector_q);
            REG_INT_STATUS: v = 32'(n.ist[l]);
            REG_INTF_CAP:   v = 32'(8'h10 | IRQ_SUPPORTED);
            REG_STS: v = ((32'(BUFFER_BYTES) - 32'(n.fp)) << 8) | 32'(n.sts[l]);
            REG_DATA_FIFO: begin
              if (n.cst[l] != CST_COMPLETION) begin
                v = 32'h0000_00ff;
              end else begin
                v    = (n.fp < BUFFER_BYTES) ? 32'(ram_rdata) : 32'h0;
                n.fp = n.fp + 1'b1;
                if (32'(n.fp) >= hlen_f(h4_q, h5_q)) begin
                  n.sts[l] = 8'h80;
                  n.fp     = '0;
                end
              end
            end
            REG_DID_VID: v = dev_vendor_id_q;
            REG_RID:     v = 32'(revision_id_q);
            default:     v = '0;
          endcase
          out_d.rdata = v >> {off[1:0], 3'b000};
        end
      end
      MODE_HOST_WRITE: begin
        if (l < LC) begin
          case (off)
            REG_ACCESS: begin
              if (val[5] && n.act == l) begin
                n.acc[l] = n.acc[l] & ~8'h04;
                for (int c = LC - 1; c >= 0; c--) begin
                  if (!found && n.acc[c][1]) begin
                    n.acc[c] = (n.acc[c] | 8'h80) & ~8'h02;
                    nl       = 3'(c);
                    found    = 1'b1;
                  end
                end
                n = start_f(n, l, nl, backend_present_q);
              end
              if (val[4]) n.acc[l] = n.acc[l] & ~8'h10;
              if (val[3] && n.act < LC && l > n.act) begin
                n.acc[n.act] = n.acc[n.act] | 8'h10;
                n.acc[l]     = 8'h80;
                n = start_f(n, n.act, l, backend_present_q);
              end
              if (val[1]) begin
                if (n.act < LC) begin
                  n.acc[n.act] = n.acc[n.act] | 8'h04;
                  if (l != n.act) n.acc[l] = n.acc[l] | 8'h02;
                end else begin
                  n.acc[l] = n.acc[l] | 8'h20;
                  n.act    = l;
                  n = raise_f(n, l, IRQ_LOCCHG);
                end
              end
            end
            REG_INT_ENABLE: n.ien[l] = val & INT_EN_MASK;
            REG_INT_STATUS: begin
              if (|(val[7:0] & IRQ_SUPPORTED) && |(n.ist[l] & IRQ_SUPPORTED)) n.pend = 1'b0;
              n.ist[l] = n.ist[l] & ~(val[7:0] & IRQ_SUPPORTED);
            end
            REG_STS: begin
              if (val[6]) begin
                if (n.cst[l] == CST_IDLE) begin
                  n.sts[l] = 8'h40;
                  n.cst[l] = CST_READY;
                  n = raise_f(n, l, IRQ_READY);
                end else if (n.cst[l] == CST_COMPLETION || n.cst[l] == CST_EXECUTION ||
                             n.cst[l] == CST_RECEPTION) begin
                  n = start_f(n, l, l, backend_present_q);
                end
              end
              if (val[5]) begin
                n.fp = '0;
                if (backend_present_q) begin
                  out_d.send_request  = 1'b1;
                  out_d.send_locality = l;
                  out_d.send_length   = 13'(hlen_f(h4_q, h5_q));
                  n.rp     = '0;
                  n.cst[l] = CST_EXECUTION;
                end else begin
                  ap_fail  = 1'b1;
                  tag_d    = h1_q + 8'd3;
                  h1_d     = h1_q + 8'd3;
                  h4_d     = 8'h00;
                  h5_d     = 8'h0a;
                  n.sts[l] = 8'h90;
                  n.cst[l] = CST_COMPLETION;
                  n = raise_f(n, l, IRQ_DATA);
                end
              end
              if (val[1]) n.fp = '0;
            end
            REG_DATA_FIFO: begin
              if (n.cst[l] == CST_READY || n.cst[l] == CST_RECEPTION) begin
                n.cst[l] = CST_RECEPTION;
                if (n.fp < BUFFER_BYTES) begin
                  ap_we    = 1'b1;
                  ap_waddr = n.fp[AW-1:0];
                  ap_wdata = val[7:0];
                  if (32'(n.fp) == 32'd1) h1_d = val[7:0];
                  if (32'(n.fp) == 32'd4) h4_d = val[7:0];
                  if (32'(n.fp) == 32'd5) h5_d = val[7:0];
                  n.fp = n.fp + 1'b1;
                end
                if (32'(n.fp) > 32'd5) begin
                  n.sts[l] = (hlen_f(h4_d, h5_d) > 32'(n.fp)) ? 8'h88 : 8'h80;
                end
              end
            end
            default: ;
          endcase
        end
      end
      MODE_RESP_BYTE: begin
        if (n.abt < LC || (n.act < LC && n.cst[n.act] == CST_EXECUTION)) begin
          if (n.rp < BUFFER_BYTES) begin
            ap_we    = 1'b1;
            ap_waddr = n.rp[AW-1:0];
            ap_wdata = b;
            if (32'(n.rp) == 32'd1) h1_d = b;
            if (32'(n.rp) == 32'd4) h4_d = b;
            if (32'(n.rp) == 32'd5) h5_d = b;
            n.rp = n.rp + 1'b1;
          end
          if (item_q.resp_last) begin
            n.rp = '0;
            if (n.abt < LC) n = finish_f(n);
            else            n = complete_f(n);
          end
        end
      end
      MODE_CMD_FETCH: begin
        out_d.rdata = (fi32 < BUFFER_BYTES) ? 32'(ram_rdata) : 32'h0;
      end
      MODE_BACKEND_GONE: begin
        if (n.abt < LC || (n.act < LC && n.cst[n.act] == CST_EXECUTION)) begin
          n.rp = '0;
          n = complete_f(n);
          if (n.abt < LC) n = finish_f(n);
        end
      end
      default: ;
    endcase
    out_d.irq_line = n.pend;
    ctl_d = n;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (st_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      S_FAIL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_q);
        ram_wdata = (cnt_q == 4'd1) ? tag_q : fail_byte(cnt_q);
      end
      S_APPLY: begin
        ram_we    = ap_we && go;
        ram_waddr = ap_waddr;
        ram_wdata = ap_wdata;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (st_q)
      S_CLR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) st_d = S_IDLE;
      end
      S_IDLE:  if (in_acc) st_d = S_READ;
      S_READ:  st_d = S_APPLY;
      S_APPLY: begin
        if (go) begin
          out_valid_d = 1'b1;
          cnt_d       = '0;
          st_d        = ap_fail ? S_FAIL : S_IDLE;
        end
      end
      S_FAIL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == FAIL_LEN - 4'd1) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q              <= S_CLR;
      ctl_q             <= ctl_reset();
      out_valid_q       <= 1'b0;
      h1_q              <= '0;
      h4_q              <= '0;
      h5_q              <= '0;
      cnt_q             <= '0;
      clr_q             <= '0;
      irq_vector_q      <= 8'h00;
      backend_present_q <= 1'b1;
      dev_vendor_id_q   <= 32'h0001_0001;
      revision_id_q     <= 8'h01;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      if (st_q == S_APPLY && go) begin
        ctl_q <= ctl_d;
        h1_q  <= h1_d;
        h4_q  <= h4_d;
        h5_q  <= h5_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IRQ_VECTOR:      irq_vector_q      <= cfg_wdata_i[7:0];
          CFG_BACKEND_PRESENT: backend_present_q <= cfg_wdata_i[0];
          CFG_DEV_VENDOR_ID:   dev_vendor_id_q   <= cfg_wdata_i;
          CFG_REVISION_ID:     revision_id_q     <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_word_i;
    if (st_q == S_APPLY && go) begin
      out_q <= out_d;
      tag_q <= tag_d;
    end
  end

`ifndef SYNTH
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while busy");

  a_result_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == S_APPLY))
    else $error("result without update step");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE || st_q == S_READ) |-> !ram_we)
    else $error("buffer write outside update");
`endif

endmodule

>>> test/tpm_tis_checker.sv
// ----------------------------------------------------------------------------
// TIS front end checker
// Watches the word channels and the register port, keeps its own copy of the
// TIS state, predicts one result word per accepted input word and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpm_tis_checker
  import tpmtis_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_word_t             in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_word_t            out_word_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int NBUF = BUFFER_BYTES_DEF;
  localparam int NLOC = LOCALITY_COUNT_DEF;

  logic [7:0]  vec_q, rid_q;
  logic        present_q;
  logic [31:0] didvid_q;
  logic [7:0]  mem [NBUF];
  int unsigned fifo_ptr, resp_ptr;
  logic [2:0]  act_loc, abort_loc, next_loc;
  logic        irq_q;
  cmd_state_e  cst [NLOC];
  logic [7:0]  acc [NLOC];
  logic [7:0]  sts [NLOC];
  logic [31:0] ien [NLOC];
  logic [7:0]  ist [NLOC];

  out_word_t expected_q[$];
  int        errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic bit loc_ok(logic [2:0] l);
    return l < NLOC;
  endfunction

  function automatic int unsigned hdr_len();
    int unsigned n;
    n = {mem[4], mem[5]};
    return n > NBUF ? NBUF : n;
  endfunction

  task automatic raise_irq(logic [2:0] l, logic [7:0] m);
    if (loc_ok(l) && !irq_q && ien[l][31] && (ien[l][7:0] & m) != 0 && (ist[l] & m) == 0) begin
      irq_q = 1'b1;
      ist[l] |= m;
    end
  endtask

  task automatic finish_abort();
    logic [2:0] ab, nx;
    ab = abort_loc;
    nx = next_loc;
    fifo_ptr = 0;
    act_loc = nx;
    if (loc_ok(ab) && ab == nx) begin
      cst[ab] = CST_READY;
      sts[ab] = 8'h40;
      raise_irq(ab, IRQ_READY);
    end
    if (ab != nx && loc_ok(nx)) begin
      if (loc_ok(ab)) acc[ab] &= ~8'h20;
      acc[nx] |= 8'h20;
      raise_irq(nx, IRQ_LOCCHG);
    end
    abort_loc = NO_LOC;
  endtask

  task automatic start_abort(logic [2:0] l, logic [2:0] nl);
    abort_loc = l;
    next_loc = nl;
    if (!(loc_ok(l) && cst[l] == CST_EXECUTION && present_q)) finish_abort();
  endtask

  task automatic complete_active();
    if (loc_ok(act_loc)) begin
      sts[act_loc] = 8'h90;
      cst[act_loc] = CST_COMPLETION;
      raise_irq(act_loc, IRQ_DATA);
    end
  endtask

  function automatic bit busy();
    return loc_ok(abort_loc) || (loc_ok(act_loc) && cst[act_loc] == CST_EXECUTION);
  endfunction

  task automatic host_read(logic [14:0] a, logic [2:0] l, output logic [31:0] r);
    logic [31:0] v;
    v = '0;
    case ({a[11:2], 2'b00})
      REG_ACCESS: begin
        if (act_loc == l) acc[l] |= 8'h20; else acc[l] &= ~8'h20;
        v = 32'(acc[l]);
      end
      REG_INT_ENABLE: v = ien[l];
      REG_INT_VECTOR: v = 32'(vec_q);
      REG_INT_STATUS: v = 32'(ist[l]);
      REG_INTF_CAP:   v = 32'h10 | 32'(IRQ_SUPPORTED);
      REG_STS:        v = ((NBUF - fifo_ptr) << 8) | 32'(sts[l]);
      REG_DATA_FIFO: begin
        if (cst[l] != CST_COMPLETION) v = 32'hff;
        else begin
          v = fifo_ptr < NBUF ? 32'(mem[fifo_ptr]) : 32'h0;
          fifo_ptr++;
          if (fifo_ptr >= hdr_len()) begin
            sts[l] = 8'h80;
            fifo_ptr = 0;
          end
        end
      end
      REG_DID_VID: v = didvid_q;
      REG_RID:     v = 32'(rid_q);
      default: ;
    endcase
    r = v >> (a[1:0] * 8);
  endtask

  task automatic host_write(logic [14:0] a, logic [2:0] l, logic [31:0] d, inout out_word_t o);
    logic [2:0] nl;
    logic [7:0] tag;
    case (a[11:0])
      REG_ACCESS: begin
        if (d[5] && act_loc == l) begin
          nl = NO_LOC;
          acc[l] &= ~8'h04;
          for (int c = NLOC - 1; c >= 0; c--) begin
            if (acc[c][1]) begin
              acc[c] = (acc[c] | 8'h80) & ~8'h02;
              nl = 3'(c);
              break;
            end
          end
          start_abort(l, nl);
        end
        if (d[4]) acc[l] &= ~8'h10;
        if (d[3] && loc_ok(act_loc) && l > act_loc) begin
          acc[act_loc] |= 8'h10;
          acc[l] = 8'h80;
          start_abort(act_loc, l);
        end
        if (d[1]) begin
          if (loc_ok(act_loc)) begin
            acc[act_loc] |= 8'h04;
            if (l != act_loc) acc[l] |= 8'h02;
          end else begin
            acc[l] |= 8'h20;
            act_loc = l;
            raise_irq(l, IRQ_LOCCHG);
          end
        end
      end
      REG_INT_ENABLE: ien[l] = d & INT_EN_MASK;
      REG_INT_STATUS: begin
        if ((d[7:0] & IRQ_SUPPORTED) != 0 && (ist[l] & IRQ_SUPPORTED) != 0) irq_q = 1'b0;
        ist[l] &= ~(d[7:0] & IRQ_SUPPORTED);
      end
      REG_STS: begin
        if (d[6]) begin
          if (cst[l] == CST_IDLE) begin
            sts[l] = 8'h40;
            cst[l] = CST_READY;
            raise_irq(l, IRQ_READY);
          end else if (cst[l] != CST_READY) begin
            start_abort(l, l);
          end
        end
        if (d[5]) begin
          fifo_ptr = 0;
          if (present_q) begin
            o.send_request  = 1'b1;
            o.send_locality = l;
            o.send_length   = 13'(hdr_len());
            resp_ptr = 0;
            cst[l] = CST_EXECUTION;
          end else begin
            tag = mem[1];
            for (int i = 0; i < 10; i++) mem[i] = 8'h00;
            mem[5] = 8'h0a;
            mem[9] = 8'h09;
            mem[1] = tag + 8'd3;
            sts[l] = 8'h90;
            cst[l] = CST_COMPLETION;
            raise_irq(l, IRQ_DATA);
          end
        end
        if (d[1]) fifo_ptr = 0;
      end
      REG_DATA_FIFO: begin
        if (cst[l] == CST_READY || cst[l] == CST_RECEPTION) begin
          cst[l] = CST_RECEPTION;
          if (fifo_ptr < NBUF) mem[fifo_ptr++] = d[7:0];
          if (fifo_ptr > 5) sts[l] = hdr_len() > fifo_ptr ? 8'h88 : 8'h80;
        end
      end
      default: ;
    endcase
  endtask

  task automatic tis_step(in_word_t w);
    out_word_t o;
    logic [2:0] l;
    o = '0;
    l = w.addr[14:12];
    case (w.mode)
      MODE_HOST_READ:  if (loc_ok(l)) host_read(w.addr, l, o.rdata);
      MODE_HOST_WRITE: if (loc_ok(l)) host_write(w.addr, l, w.wdata, o);
      MODE_RESP_BYTE: begin
        if (busy()) begin
          if (resp_ptr < NBUF) mem[resp_ptr++] = w.resp_byte;
          if (w.resp_last) begin
            resp_ptr = 0;
            if (loc_ok(abort_loc)) finish_abort(); else complete_active();
          end
        end
      end
      MODE_CMD_FETCH: o.rdata = 32'(mem[w.fetch_index]);
      MODE_BACKEND_GONE: begin
        if (busy()) begin
          resp_ptr = 0;
          complete_active();
          if (loc_ok(abort_loc)) finish_abort();
        end
      end
      default: ;
    endcase
    o.irq_line = irq_q;
    expected_q.push_back(o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      vec_q = 8'd0; present_q = 1'b1; didvid_q = 32'h0001_0001; rid_q = 8'd1;
      for (int i = 0; i < NBUF; i++) mem[i] = 8'h00;
      fifo_ptr = 0; resp_ptr = 0;
      act_loc = NO_LOC; abort_loc = NO_LOC; next_loc = NO_LOC; irq_q = 1'b0;
      for (int c = 0; c < NLOC; c++) begin
        cst[c] = CST_IDLE; acc[c] = 8'h80; sts[c] = 8'h00; ien[c] = 32'h08; ist[c] = 8'h00;
      end
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IRQ_VECTOR:      vec_q = cfg_wdata_i[7:0];
          CFG_BACKEND_PRESENT: present_q = cfg_wdata_i[0];
          CFG_DEV_VENDOR_ID:   didvid_q = cfg_wdata_i;
          CFG_REVISION_ID:     rid_q = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) tis_step(in_word_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_word_i);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_word_i.rdata !== e.rdata) begin
            $error("rdata exp %h got %h", e.rdata, out_word_i.rdata); errors++;
          end
          if (out_word_i.irq_line !== e.irq_line) begin
            $error("irq_line exp %h got %h", e.irq_line, out_word_i.irq_line); errors++;
          end
          if (out_word_i.send_request !== e.send_request) begin
            $error("send_request exp %h got %h", e.send_request, out_word_i.send_request);
            errors++;
          end
          if (out_word_i.send_locality !== e.send_locality) begin
            $error("send_locality exp %h got %h", e.send_locality, out_word_i.send_locality);
            errors++;
          end
          if (out_word_i.send_length !== e.send_length) begin
            $error("send_length exp %h got %h", e.send_length, out_word_i.send_length);
            errors++;
          end
        end
      end
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// TIS front end testbench
// Drives host register traffic, command sequences, backend responses and
// fetches with random idling on both channels; the checker's error count and a watchdog give the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tpmtis_pkg::*;

  localparam int WATCHDOG = 20000;

  logic                 clk, rst_n;
  logic                 in_valid, in_stall, out_valid, out_stall;
  in_word_t             in_word;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_wdata;
  int                   errors, pending;
  int                   idle_cycles = 0;
  bit                   quiet;
  bit                   timed_out = 1'b0;

  tpm_tis_register_interface u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  tpm_tis_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_word_i(out_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stalls in bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) timed_out <= 1'b1;
  end

  initial begin
    @(posedge timed_out);
    $display("FAILURE");
    $finish;
  end

  // valid stays high into the next word; idling and drain drop it
  task automatic send_word(in_word_t w);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic in_word_t noise_fields(logic [2:0] m);
    in_word_t w;
    w.mode = m;
    w.addr = 15'($urandom);
    w.wdata = $urandom;
    w.resp_byte = 8'($urandom);
    w.resp_last = 1'($urandom);
    w.fetch_index = 12'($urandom);
    return w;
  endfunction

  task automatic reg_op(logic [2:0] m, logic [2:0] l, logic [11:0] off, logic [31:0] d);
    in_word_t w;
    w = noise_fields(m);
    w.addr = {l, off};
    w.wdata = d;
    send_word(w);
  endtask

  task automatic resp_op(logic [7:0] b, logic last);
    in_word_t w;
    w = noise_fields(MODE_RESP_BYTE);
    w.resp_byte = b;
    w.resp_last = last;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e i, logic [31:0] d);
    cfg_we <= 1'b1; cfg_idx <= i; cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [11:0] pick_off();
    logic [11:0] t [10] = '{REG_ACCESS, REG_INT_ENABLE, REG_INT_VECTOR, REG_INT_STATUS,
                            REG_INTF_CAP, REG_STS, REG_DATA_FIFO, REG_DID_VID, REG_RID, 12'h0};
    int k;
    k = $urandom_range(0, 9);
    if (k == 9) return 12'($urandom);
    return t[k] | ($urandom_range(0, 3) == 0 ? 12'($urandom_range(0, 3)) : 12'h0);
  endfunction

  // a command transaction: get locality, ready, body, go, fetches, response, read back
  task automatic command_seq(logic [2:0] l);
    int len;
    len = $urandom_range(6, 14);
    reg_op(MODE_HOST_WRITE, l, REG_INT_ENABLE, $urandom);
    reg_op(MODE_HOST_WRITE, l, REG_ACCESS, 32'h02);
    reg_op(MODE_HOST_WRITE, l, REG_STS, 32'h40);
    for (int i = 0; i < len; i++)
      reg_op(MODE_HOST_WRITE, l, REG_DATA_FIFO,
             i == 4 ? 0 : (i == 5 ? len + $urandom_range(0, 2) : $urandom));
    reg_op(MODE_HOST_READ, l, REG_STS, 0);
    if ($urandom_range(0, 9) == 0) reg_op(MODE_HOST_WRITE, l, REG_STS, 32'h40);
    reg_op(MODE_HOST_WRITE, l, REG_STS, 32'h20);
    for (int i = 0; i < 4; i++) begin
      in_word_t w;
      w = noise_fields(MODE_CMD_FETCH);
      w.fetch_index = 12'($urandom_range(0, 15));
      send_word(w);
    end
    if ($urandom_range(0, 7) == 0) reg_op(MODE_HOST_WRITE, l, REG_STS, 32'h40);
    if ($urandom_range(0, 9) == 0) send_word(noise_fields(MODE_BACKEND_GONE));
    else for (int i = 0; i < 10; i++) resp_op(i == 5 ? 8'd10 : 8'($urandom), i == 9);
    for (int i = 0; i < 11; i++) reg_op(MODE_HOST_READ, l, REG_DATA_FIFO, 0);
    reg_op(MODE_HOST_READ, l, REG_INT_STATUS, 0);
    reg_op(MODE_HOST_WRITE, l, REG_INT_STATUS, 32'hff);
    reg_op(MODE_HOST_WRITE, l, REG_ACCESS, $urandom_range(0, 1) ? 32'h20 : $urandom);
  endtask

  initial begin
    int sent;
    in_word_t w;
    rst_n = 1'b0; in_valid = 1'b0; in_word = '0;
    cfg_we = 1'b0; cfg_idx = CFG_IRQ_VECTOR; cfg_wdata = '0;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(CFG_IRQ_VECTOR, 32'hff);
    cfg_write(CFG_DEV_VENDOR_ID, 32'hffff_ffff);
    cfg_write(CFG_REVISION_ID, 32'h0);
    cfg_write(CFG_BACKEND_PRESENT, 32'h1);

    // directed: fixed registers, lanes, absent locality, unused modes
    reg_op(MODE_HOST_READ, 0, REG_INT_VECTOR, 0);
    reg_op(MODE_HOST_READ, 1, REG_DID_VID | 12'h3, 0);
    reg_op(MODE_HOST_READ, 2, REG_RID, 0);
    reg_op(MODE_HOST_READ, 3, REG_INTF_CAP | 12'h1, 0);
    reg_op(MODE_HOST_READ, 7, REG_ACCESS, 0);
    reg_op(MODE_HOST_WRITE, 7, REG_ACCESS, 32'h02);
    reg_op(MODE_HOST_READ, 4, REG_DATA_FIFO, 0);
    reg_op(MODE_HOST_READ, 0, 12'h7fc, 0);
    send_word(noise_fields(3'd5));
    send_word(noise_fields(3'd7));
    w = noise_fields(MODE_CMD_FETCH); w.fetch_index = 12'hfff; send_word(w);
    resp_op(8'hff, 1'b1);
    send_word(noise_fields(MODE_BACKEND_GONE));
    // request contention and seize
    reg_op(MODE_HOST_WRITE, 1, REG_ACCESS, 32'h02);
    reg_op(MODE_HOST_WRITE, 3, REG_ACCESS, 32'h02);
    reg_op(MODE_HOST_WRITE, 2, REG_ACCESS, 32'h02);
    reg_op(MODE_HOST_WRITE, 4, REG_ACCESS, 32'h08);
    reg_op(MODE_HOST_READ, 1, REG_ACCESS, 0);
    reg_op(MODE_HOST_WRITE, 4, REG_ACCESS, 32'h20);
    reg_op(MODE_HOST_WRITE, 3, REG_ACCESS, 32'h20);
    command_seq(3);
    drain();

    // failure responses with no backend
    cfg_write(CFG_BACKEND_PRESENT, 32'h0);
    cfg_write(CFG_IRQ_VECTOR, 32'h0);
    command_seq(0);
    drain();
    cfg_write(CFG_BACKEND_PRESENT, 32'h1);
    cfg_write(CFG_DEV_VENDOR_ID, 32'h0);
    cfg_write(CFG_REVISION_ID, 32'hff);

    sent = 0;
    while (sent < 1750) begin
      if (sent > 1500) quiet = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        command_seq(3'($urandom_range(0, 4)));
        sent += 40;
      end else begin
        for (int i = 0; i < 20; i++) begin
          w = noise_fields(3'($urandom_range(0, 5)));
          if (w.mode <= MODE_HOST_WRITE) w.addr = {3'($urandom_range(0, 5)), pick_off()};
          if ($urandom_range(0, 1)) w.fetch_index = 12'($urandom_range(0, 15));
          send_word(w);
        end
        sent += 20;
      end
      if (sent % 400 < 40) begin
        drain();
        cfg_write(CFG_BACKEND_PRESENT, $urandom);
        cfg_write(CFG_IRQ_VECTOR, $urandom);
        cfg_write(CFG_DEV_VENDOR_ID, $urandom);
        cfg_write(CFG_REVISION_ID, $urandom);
      end
    end
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
